// ===== rtl/rgbhsv_pkg.sv =====
// Package for the RGB to HSV converter: widths, constants and payload types.
`default_nettype none
package rgbhsv_pkg;

  // Channel width and derived limits
  localparam int unsigned CHANNEL_BITS = 8;
  localparam int unsigned CHAN_MAX     = (1 << CHANNEL_BITS) - 1;

  // Hue scale: 1/64 degree, so 60 degrees is one sixth of a turn
  localparam int unsigned HUE_SIXTH = 3840;
  localparam int unsigned HUE_TURN  = 23040;
  localparam int unsigned HUE_W     = 15;

  // Quotient bits cover both 3840 (hue) and CHAN_MAX (saturation)
  localparam int unsigned QUO_W = (CHANNEL_BITS > 12) ? CHANNEL_BITS : 12;
  localparam int unsigned NUM_W = CHANNEL_BITS + QUO_W;

  // Input register, numerator register, one stage per quotient bit, output register
  localparam int unsigned LATENCY = QUO_W + 3;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_e;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0]        hue;
    logic [CHANNEL_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0] brightness;
  } hsv_t;

  // Payload of the first stage
  typedef struct packed {
    sector_e                 sector;
    logic                    neg;
    logic [CHANNEL_BITS-1:0] mag;
    logic [CHANNEL_BITS-1:0] delta;
    logic [CHANNEL_BITS-1:0] max;
  } front_t;

  // Payload carried through the divider stages
  typedef struct packed {
    sector_e                 sector;
    logic                    neg;
    logic [CHANNEL_BITS-1:0] delta;
    logic [CHANNEL_BITS-1:0] max;
    logic [NUM_W-1:0]        hrem;
    logic [NUM_W-1:0]        srem;
    logic [QUO_W-1:0]        hq;
    logic [QUO_W-1:0]        sq;
  } div_t;

endpackage
`default_nettype wire

// ===== rtl/rgb_to_hsv_converter.sv =====
// Top level: pipelined RGB to HSV converter with bit-per-stage dividers.
// An accepted pixel passes the front register, the divider registers and the output register
// in turn; the result strobe comes from the output register.
// Throughput: one pixel per clock; busy stays low, as every stage advances each cycle.
// The divider pipeline sets the depth: one quotient bit per stage for hue and saturation.
// Reset clears all valid bits at once; payload registers are not reset.
// The receiver cannot stall: each result shows for exactly one cycle.
`default_nettype none
module rgb_to_hsv_converter
  import rgbhsv_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   start,
  output logic        busy,
  input  wire pixel_t pixel_i,
  output logic        result_valid_o,
  output hsv_t        result_o
);

  logic                    front_valid_q;
  front_t                  front_d, front_q;
  logic [QUO_W:0]          div_valid_q;
  div_t                    div_d [QUO_W+1];
  div_t                    div_q [QUO_W+1];
  logic                    out_valid_q;
  hsv_t                    out_d, out_q;

  logic [CHANNEL_BITS-1:0] mx, mn, da, db;
  logic [QUO_W:0]          hq_ceil;
  logic signed [15:0]      frac, hue_s;

  // Never hold off a pixel
  assign busy = 1'b0;

  // Find max, min, sector and the signed channel difference
  always_comb begin
    mx = pixel_i.red;
    mn = pixel_i.red;
    if (pixel_i.green > mx) mx = pixel_i.green;
    if (pixel_i.blue  > mx) mx = pixel_i.blue;
    if (pixel_i.green < mn) mn = pixel_i.green;
    if (pixel_i.blue  < mn) mn = pixel_i.blue;
    if (mx == pixel_i.red) begin
      front_d.sector = SEC_RED;
      da = pixel_i.green;
      db = pixel_i.blue;
    end else if (mx == pixel_i.green) begin
      front_d.sector = SEC_GREEN;
      da = pixel_i.blue;
      db = pixel_i.red;
    end else begin
      front_d.sector = SEC_BLUE;
      da = pixel_i.red;
      db = pixel_i.green;
    end
    front_d.neg   = (da < db);
    front_d.mag   = front_d.neg ? (db - da) : (da - db);
    front_d.delta = mx - mn;
    front_d.max   = mx;
  end

  // Form numerators for both divisions, then resolve one quotient bit per stage,
  // most significant first
  always_comb begin
    div_d[0].sector = front_q.sector;
    div_d[0].neg    = front_q.neg;
    div_d[0].delta  = front_q.delta;
    div_d[0].max    = front_q.max;
    div_d[0].hrem   = NUM_W'(front_q.mag) * NUM_W'(HUE_SIXTH);
    div_d[0].srem   = NUM_W'(front_q.delta) * NUM_W'(CHAN_MAX);
    div_d[0].hq     = '0;
    div_d[0].sq     = '0;
    for (int s = 0; s < QUO_W; s++) begin
      div_d[s+1] = div_q[s];
      if (div_q[s].hrem >= (NUM_W'(div_q[s].delta) << (QUO_W - 1 - s))) begin
        div_d[s+1].hrem = div_q[s].hrem - (NUM_W'(div_q[s].delta) << (QUO_W - 1 - s));
        div_d[s+1].hq   = {div_q[s].hq[QUO_W-2:0], 1'b1};
      end else begin
        div_d[s+1].hq   = {div_q[s].hq[QUO_W-2:0], 1'b0};
      end
      if (div_q[s].srem >= (NUM_W'(div_q[s].max) << (QUO_W - 1 - s))) begin
        div_d[s+1].srem = div_q[s].srem - (NUM_W'(div_q[s].max) << (QUO_W - 1 - s));
        div_d[s+1].sq   = {div_q[s].sq[QUO_W-2:0], 1'b1};
      end else begin
        div_d[s+1].sq   = {div_q[s].sq[QUO_W-2:0], 1'b0};
      end
    end
  end

  // Round toward minus infinity, add the sector offset and wrap
  always_comb begin
    hq_ceil = {1'b0, div_q[QUO_W].hq} + (QUO_W+1)'(div_q[QUO_W].hrem != '0);
    frac    = div_q[QUO_W].neg ? -16'(hq_ceil) : 16'(div_q[QUO_W].hq);
    case (div_q[QUO_W].sector)
      SEC_RED:   hue_s = frac;
      SEC_GREEN: hue_s = frac + 16'(2 * HUE_SIXTH);
      SEC_BLUE:  hue_s = frac + 16'(4 * HUE_SIXTH);
      default:   hue_s = frac;
    endcase
    if (hue_s < 0) hue_s = hue_s + 16'(HUE_TURN);
    out_d.hue        = (div_q[QUO_W].delta == '0) ? '0 : HUE_W'(hue_s);
    out_d.saturation = (div_q[QUO_W].max == '0) ? '0 : div_q[QUO_W].sq[CHANNEL_BITS-1:0];
    out_d.brightness = div_q[QUO_W].max;
  end

  // Advance valid bits every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_valid_q <= 1'b0;
      div_valid_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      front_valid_q <= start && !busy;
      div_valid_q   <= {div_valid_q[QUO_W-1:0], front_valid_q};
      out_valid_q   <= div_valid_q[QUO_W];
    end
  end

  // Advance payload every cycle
  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    for (int s = 0; s <= QUO_W; s++) begin
      div_q[s] <= div_d[s];
    end
    out_q <= out_d;
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

endmodule
`default_nettype wire

// ===== rtl/rgbhsv_checker.sv =====
// Port checker for the RGB to HSV converter, bound to the top level.
`default_nettype none
module rgbhsv_checker
  import rgbhsv_pkg::*;
(
  input wire logic   clk_i,
  input wire logic   rst_ni,
  input wire logic   start,
  input wire logic   busy,
  input wire pixel_t pixel_i,
  input wire logic   result_valid_o,
  input wire hsv_t   result_o
);

  localparam int unsigned CNT_W = $clog2(LATENCY + 1);

  logic [CNT_W-1:0] settle_q;

  // Count cycles since reset so that the latency check sees a filled pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= '0;
    end else if (settle_q != CNT_W'(LATENCY)) begin
      settle_q <= settle_q + CNT_W'(1);
    end
  end

  // Pixels are never held off
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  // One beat out for each beat in, a fixed latency later
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (settle_q == CNT_W'(LATENCY)) |-> (result_valid_o == $past(start && !busy, LATENCY)))
    else $error("result strobe does not match accepted beat");

  // Hue stays below a full turn
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.hue < HUE_W'(HUE_TURN)))
    else $error("hue out of range");

  // Black pixel has no saturation
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.brightness == '0)) |-> (result_o.saturation == '0))
    else $error("saturation on black pixel");

  // A coloured hue implies a nonzero saturation
  a_hue_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.hue != '0)) |-> (result_o.saturation != '0))
    else $error("hue without saturation");

endmodule

bind rgb_to_hsv_converter rgbhsv_checker u_rgbhsv_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .pixel_i        (pixel_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
`default_nettype wire

// ===== verif/rgb_to_hsv_converter_tb.sv =====
// Self-checking testbench for the RGB to HSV converter: directed and random pixels.
`timescale 1ns / 1ps
module rgb_to_hsv_converter_tb;
  import rgbhsv_pkg::*;

  // Signed copies of the hue and channel constants, so that the arithmetic stays signed
  localparam int HueSixth = HUE_SIXTH;
  localparam int HueTurn  = HUE_TURN;
  localparam int ChanTop  = CHAN_MAX;

  logic   clk;
  logic   rst_n;
  logic   start;
  logic   busy;
  pixel_t pixel;
  logic   result_valid;
  hsv_t   result;

  hsv_t        pending_hsv[$];
  int unsigned mismatch_count;
  bit          idle_on;

  rgb_to_hsv_converter i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .pixel_i        (pixel),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  // Free-running clock, 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Quotient rounded towards minus infinity, for a positive divisor
  function automatic int floor_quot(input int num, input int den);
    if (num >= 0) begin
      return num / den;
    end
    return -((-num + den - 1) / den);
  endfunction

  // Expected hue, saturation and brightness of one pixel
  function automatic hsv_t hsv_of(input pixel_t px);
    int   r, g, b;
    int   top, bottom, span, h, s;
    hsv_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    top = r;
    bottom = r;
    if (g > top) top = g;
    if (b > top) top = b;
    if (g < bottom) bottom = g;
    if (b < bottom) bottom = b;
    span = top - bottom;
    h = 0;
    s = 0;
    // Red wins ties over green, green over blue; a grey pixel has hue zero
    if (span != 0) begin
      if (top == r) begin
        h = floor_quot(HueSixth * (g - b), span);
        if (h < 0) h += HueTurn;
      end else if (top == g) begin
        h = 2 * HueSixth + floor_quot(HueSixth * (b - r), span);
      end else begin
        h = 4 * HueSixth + floor_quot(HueSixth * (r - g), span);
      end
    end
    if (top != 0) s = (span * ChanTop) / top;
    res.hue        = h[HUE_W-1:0];
    res.saturation = s[CHANNEL_BITS-1:0];
    res.brightness = top[CHANNEL_BITS-1:0];
    return res;
  endfunction

  task automatic note_mismatch(input string why);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s", $time, why);
    end
  endtask

  // Check each result beat against the oldest expectation, then record any accepted pixel
  always @(posedge clk) begin : check_beats
    hsv_t want;
    if (rst_n) begin
      if (result_valid) begin
        if (pending_hsv.size() == 0) begin
          note_mismatch($sformatf("unexpected result hue=%0d sat=%0d val=%0d",
                                  result.hue, result.saturation, result.brightness));
        end else begin
          want = pending_hsv.pop_front();
          if (result.hue !== want.hue || result.saturation !== want.saturation ||
              result.brightness !== want.brightness) begin
            note_mismatch($sformatf("expected hue=%0d sat=%0d val=%0d, got hue=%0d sat=%0d val=%0d",
                                    want.hue, want.saturation, want.brightness,
                                    result.hue, result.saturation, result.brightness));
          end
        end
      end
      if (start && !busy) begin
        pending_hsv.push_back(hsv_of(pixel));
      end
    end
  end

  // Hold start low for an idle burst of random length
  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 3)) @(posedge clk);
  endtask

  // Offer one pixel and wait for the accepting edge; start stays high for the next beat
  task automatic send_pixel(input pixel_t px);
    if (idle_on && $urandom_range(0, 3) == 0) idle_burst();
    start <= 1'b1;
    pixel <= px;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_rgb(input int r, input int g, input int b);
    pixel_t px;
    px.red   = r[CHANNEL_BITS-1:0];
    px.green = g[CHANNEL_BITS-1:0];
    px.blue  = b[CHANNEL_BITS-1:0];
    send_pixel(px);
  endtask

  // Mostly uniform pixels, with greys, tied maxima, near-greys and very dark pixels mixed in
  function automatic pixel_t random_pixel();
    pixel_t px;
    int     c, lo;
    case ($urandom_range(0, 9))
      6: begin
        c = $urandom_range(0, 255);
        px = {c[7:0], c[7:0], c[7:0]};
      end
      7: begin
        c = $urandom_range(1, 255);
        lo = $urandom_range(0, c - 1);
        case ($urandom_range(0, 2))
          0: px = {lo[7:0], c[7:0], c[7:0]};
          1: px = {c[7:0], lo[7:0], c[7:0]};
          default: px = {c[7:0], c[7:0], lo[7:0]};
        endcase
      end
      8: begin
        c = $urandom_range(1, 254);
        px.red   = 8'(c + $urandom_range(0, 2) - 1);
        px.green = 8'(c + $urandom_range(0, 2) - 1);
        px.blue  = 8'(c + $urandom_range(0, 2) - 1);
      end
      9: begin
        px.red   = 8'($urandom_range(0, 3));
        px.green = 8'($urandom_range(0, 3));
        px.blue  = 8'($urandom_range(0, 3));
      end
      default: px = pixel_t'($urandom_range(0, 32'hFF_FFFF));
    endcase
    return px;
  endfunction

  // Corners: black, greys, primaries, ties, wrap of a negative red-sector hue
  task automatic test_corner_pixels();
    send_rgb(0, 0, 0);
    send_rgb(255, 255, 255);
    send_rgb(128, 128, 128);
    send_rgb(255, 0, 0);
    send_rgb(0, 255, 0);
    send_rgb(0, 0, 255);
    send_rgb(255, 0, 1);
    send_rgb(255, 0, 255);
    send_rgb(255, 255, 0);
    send_rgb(0, 255, 255);
    send_rgb(200, 200, 200);
    send_rgb(1, 0, 0);
    send_rgb(0, 1, 0);
    send_rgb(0, 0, 1);
    send_rgb(255, 254, 254);
    send_rgb(254, 255, 255);
    send_rgb(8'h55, 8'hAA, 8'h55);
    send_rgb(8'hAA, 8'h55, 8'hAA);
    send_rgb(10, 20, 30);
    send_rgb(30, 20, 10);
  endtask

  task automatic test_random_pixels(input int count);
    repeat (count) send_pixel(random_pixel());
  endtask

  // Close the run: drain, allow the pipeline to settle, give the verdict
  task automatic finish_run();
    int waited;
    start <= 1'b0;
    waited = 0;
    while (pending_hsv.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0 && pending_hsv.size() == 0) begin
      $display("rgb_to_hsv_converter: match");
    end else begin
      $display("rgb_to_hsv_converter: mismatch");
    end
    $finish;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    pixel = '0;
    mismatch_count = 0;
    idle_on = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_pixels();
    test_random_pixels(600);
    // Back-to-back beats for the last part of the run
    idle_on = 1'b0;
    test_random_pixels(100);
    finish_run();
  end

  // Stop a hung run
  initial begin
    #1ms;
    $display("rgb_to_hsv_converter: mismatch");
    $finish;
  end

endmodule
